// ----- rtl/spq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// types and constants shared by the sorted priority queue cells and top level
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int SPQ_CAPACITY = 256;
    localparam int SYM_W        = 8;
    localparam int WEIGHT_W     = 31;
    localparam int OCC_W        = 9;

    typedef enum logic [0:0] {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [SYM_W-1:0]    symbol;
    } entry_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic   ins;
        logic   ext;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage : spq_pkg
`default_nettype wire

// ----- rtl/spq_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted queue: holds an entry, compares it with the incoming
// weight and shifts toward the tail on insert or toward the head on extract
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       occupied,
    input  wire logic       left_gt,
    input  wire entry_t     left_entry,
    input  wire entry_t     right_entry,
    output entry_t          entry,
    output logic            gt
);

    entry_t entry_reg;
    entry_t entry_next;

    // empty slot or heavier entry: the new word lands here or before
    assign gt    = !occupied || (entry_reg.weight > ctrl.new_entry.weight);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.ins)
        begin
            priority if (left_gt)
                entry_next = left_entry;
            else if (gt)
                entry_next = ctrl.new_entry;
        end
        else if (ctrl.ext)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule : spq_cell
`default_nettype wire

// ----- rtl/sorted_priority_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// minimum priority queue kept in weight order in a row of shifting cells
// ----------------------------------------------------------------------------
// the result word appears on the master side in the cycle after accept
// throughput: one word per cycle unless held off, every cell compares and shifts in parallel
// a waiting result holds off the slave side; a new word is taken in the cycle
// the waiting result is taken
// reset clears the entry count and the output valid; slot contents are not
// cleared, slots at or above the count are never read
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = SPQ_CAPACITY
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // symbol_in[7:0], weight_in[38:8], zero pad[39]
    input  wire logic [0:0]  s_tuser,  // op[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,  // symbol_out[7:0], weight_out[38:8], occupancy[47:39]
    output logic [1:0]       m_tuser   // status[1:0]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]    count_reg, count_next;
    logic                m_valid_reg, m_valid_next;
    status_t             status_reg, status_next;
    logic [SYM_W-1:0]    sym_reg, sym_next;
    logic [WEIGHT_W-1:0] weight_reg, weight_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;

    logic       accept;
    op_t        op;
    logic       full, empty;
    cell_ctrl_t ctrl;

    entry_t              cell_entry [CAPACITY];
    logic [CAPACITY-1:0] cell_gt;
    logic [CAPACITY-1:0] cell_occ;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser[0]);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    assign ctrl.ins              = accept && (op == OP_INSERT) && !full;
    assign ctrl.ext              = accept && (op == OP_EXTRACT) && !empty;
    assign ctrl.new_entry.symbol = s_tdata[7:0];
    assign ctrl.new_entry.weight = s_tdata[38:8];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t left_e, right_e;
        logic   left_g;

        assign cell_occ[i] = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_head
            assign left_e = '0;
            assign left_g = 1'b0;
        end
        else
        begin : g_mid
            assign left_e = cell_entry[i-1];
            assign left_g = cell_gt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_e = '0;
        end
        else
        begin : g_body
            assign right_e = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (cell_occ[i]),
            .left_gt     (left_g),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i])
        );
    end

    always_comb
    begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_tready;
        status_next  = status_reg;
        sym_next     = sym_reg;
        weight_next  = weight_reg;
        occ_next     = occ_reg;
        if (ctrl.ins)
            count_next = count_reg + CNT_W'(1);
        else if (ctrl.ext)
            count_next = count_reg - CNT_W'(1);
        if (accept)
        begin
            m_valid_next = 1'b1;
            sym_next     = '0;
            weight_next  = '0;
            occ_next     = OCC_W'(count_next);
            unique case (op)
                OP_INSERT:
                begin
                    status_next = full ? ST_FULL : ST_DONE;
                end
                OP_EXTRACT:
                begin
                    status_next = empty ? ST_EMPTY : ST_DONE;
                    if (!empty)
                    begin
                        sym_next    = cell_entry[0].symbol;
                        weight_next = cell_entry[0].weight;
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        sym_reg    <= sym_next;
        weight_reg <= weight_next;
        occ_reg    <= occ_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {occ_reg, weight_reg, sym_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_empty_extract: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_EXTRACT && empty) |=> (m_tvalid && m_tuser == ST_EMPTY
            && count_reg == '0))
        else $error("extract from empty queue not reported");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the count");

    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_INSERT && full) |=> (m_tuser == ST_FULL && $stable(count_reg)))
        else $error("insert into full queue not refused");

endmodule : sorted_priority_queue
`default_nettype wire
